>>> rtl/mmnb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encoding for the min-max batch normalizer.
// Used by mmnb_div and min_max_normalize_batch; depends on nothing.
package mmnb_pkg;

    localparam int DEPTH         = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int CNT_BITS      = $clog2(DEPTH + 1);
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int REM_BITS      = DIFF_BITS + 1;
    localparam int FRAC_BITS     = 16;
    localparam int SCALED_BITS   = FRAC_BITS + 1;
    localparam int STEP_BITS     = $clog2(SCALED_BITS + 1);
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((SCALED_BITS + 7) / 8) * 8;
    localparam int USER_BITS     = 2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIFF_BITS-1:0] num;
        logic [DIFF_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/mmnb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module mmnb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mmnb_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den) for num <= den,
// one quotient bit per cycle. Depends on mmnb_pkg.
module mmnb_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mmnb_pkg::div_req_t               req,
    output mmnb_pkg::div_status_t            status,
    output logic [mmnb_pkg::SCALED_BITS-1:0] quotient
);
    import mmnb_pkg::*;

    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [DIFF_BITS-1:0]   den_reg, den_next;
    logic [SCALED_BITS-1:0] quo_reg, quo_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   fits;
    logic [REM_BITS-1:0]    rem_sub;

    always_comb
    begin
        fits      = (rem_reg >= {1'b0, den_reg});
        rem_sub   = fits ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            step_next = STEP_BITS'(SCALED_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one quotient bit, keep the partial remainder
            quo_next  = {quo_reg[SCALED_BITS-2:0], fits};
            rem_next  = {rem_sub[REM_BITS-2:0], 1'b0};
            step_next = step_reg - STEP_BITS'(1);
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

>>> rtl/min_max_normalize_batch.sv
`timescale 1ns / 1ps
// Top level of the min-max batch normalizer: control sequencer, min/max tracking,
// output register. Depends on mmnb_pkg, mmnb_ram and mmnb_div.
//
//  channel | dir | tdata                        | tlast        | tuser
//  --------+-----+------------------------------+--------------+------------------------------
//  s_*     | in  | [15:0] sample (signed)       | last_sample  | -
//  m_*     | out | [16:0] scaled (unsigned Q1.16)| final_result | [0] flat_range, [1] dropped
//
// Loading takes one cycle per sample request. After the sample marked last, each
// stored sample passes through a RAM read, a step that forms x - min and starts the
// divider, the bit-serial divider plus a step while its done flag registers, and one
// push into the output register. The divider computes one quotient bit per cycle.
// Reset clears the sequencer, counters and output valid; the sample RAM is not
// cleared. A stalled output only holds the push; the last result may wait while
// the next batch already loads.
module min_max_normalize_batch (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mmnb_pkg::IN_DATA_BITS-1:0]  s_tdata,  // [15:0] sample
    input  logic                               s_tlast,  // last_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mmnb_pkg::OUT_DATA_BITS-1:0] m_tdata,  // [16:0] scaled, rest zero
    output logic                               m_tlast,  // final_result
    output logic [mmnb_pkg::USER_BITS-1:0]     m_tuser   // [0] flat_range, [1] dropped
);
    import mmnb_pkg::*;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [CNT_BITS-1:0]           count_reg, count_next;
    logic                          ovf_reg, ovf_next;
    logic                          flat_reg, flat_next;
    logic [ADDR_BITS-1:0]          rd_idx_reg, rd_idx_next;

    logic                          out_valid_reg, out_valid_next;
    logic [SCALED_BITS-1:0]        out_scaled_reg, out_scaled_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_flat_reg, out_flat_next;
    logic                          out_drop_reg, out_drop_next;

    logic                          in_accept;
    logic                          room;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic                          ram_we;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          out_free;
    logic                          push;
    logic                          last_item;
    logic                          div_start;
    logic [DIFF_BITS-1:0]          div_num;
    logic [DIFF_BITS-1:0]          div_den;
    div_req_t                      div_req;
    div_status_t                   div_stat;
    logic [SCALED_BITS-1:0]        div_quo;

    assign x_in      = s_tdata[SAMPLE_BITS-1:0];
    assign room      = (count_reg < CNT_BITS'(DEPTH));
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_item = ({1'b0, rd_idx_reg} + CNT_BITS'(1)) == count_reg;

    mmnb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wdata (x_in),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    mmnb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .status   (div_stat),
        .quotient (div_quo)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && s_tlast)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = last_item ? ST_LOAD : ST_READ;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && room;
            end
            ST_START: div_start = 1'b1;
            ST_PUSH:  push = out_free;
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Offsets from the batch minimum; both are non-negative.
    assign div_num = DIFF_BITS'({ram_rdata[SAMPLE_BITS-1], ram_rdata}
                                - {min_reg[SAMPLE_BITS-1], min_reg});
    assign div_den = DIFF_BITS'({max_reg[SAMPLE_BITS-1], max_reg}
                                - {min_reg[SAMPLE_BITS-1], min_reg});
    assign div_req = {div_start, div_num, div_den};

    // Datapath next values.
    always_comb
    begin
        min_next        = min_reg;
        max_next        = max_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        flat_next       = flat_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_scaled_next = out_scaled_reg;
        out_last_next   = out_last_reg;
        out_flat_next   = out_flat_reg;
        out_drop_next   = out_drop_reg;

        if (in_accept)
        begin
            if (room)
            begin
                // first sample of a batch seeds both bounds
                if (count_reg == '0)
                begin
                    min_next = x_in;
                    max_next = x_in;
                end
                else
                begin
                    if (x_in < min_reg)
                    begin
                        min_next = x_in;
                    end
                    if (x_in > max_reg)
                    begin
                        max_next = x_in;
                    end
                end
                count_next = count_reg + CNT_BITS'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (s_tlast)
            begin
                flat_next   = (min_next == max_next);
                rd_idx_next = '0;
            end
        end

        if (push)
        begin
            out_valid_next  = 1'b1;
            out_scaled_next = flat_reg ? '0 : div_quo;
            out_last_next   = last_item;
            out_flat_next   = flat_reg;
            out_drop_next   = ovf_reg;
            rd_idx_next     = rd_idx_reg + ADDR_BITS'(1);
            if (last_item)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            min_reg       <= '0;
            max_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            flat_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            flat_reg      <= flat_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_scaled_reg <= out_scaled_next;
        out_last_reg   <= out_last_next;
        out_flat_reg   <= out_flat_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(out_scaled_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_drop_reg, out_flat_reg};

    // Stored count never passes the buffer depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("stored count exceeds buffer depth");

    // The divider is never restarted while a quotient is in progress.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A flat batch always reports zero.
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("flat batch result not zero");

    // Output phase only runs over a non-empty batch.
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (count_reg != '0))
        else $error("output phase with empty batch");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for min_max_normalize_batch: streams batches of signed samples
// and compares every normalized result against an in-bench predictor.
// Depends on mmnb_pkg and the RTL under rtl only.
module tb;

    import mmnb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 64;     // settle time after the last owed result
    localparam int RANDOM_ITEMS  = 20;
    localparam int REPORT_LIMIT  = 10;
    localparam int FLAT_BIT      = 0;      // m_tuser bit carrying flat_range
    localparam int DROP_BIT      = 1;      // m_tuser bit carrying dropped

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = -(2 ** (SAMPLE_BITS - 1));
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;

    // One normalized result as the block should present it.
    typedef struct packed {
        logic [SCALED_BITS-1:0] scaled;
        logic                   final_result;
        logic                   flat_range;
        logic                   dropped;
    } norm_result_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;     // [15:0] sample
    logic                     s_tlast  = 1'b0;   // last_sample
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;           // [16:0] scaled, rest zero
    logic                     m_tlast;           // final_result
    logic [USER_BITS-1:0]     m_tuser;           // [0] flat_range, [1] dropped

    // Predictor state: a private copy of what the block holds for the open batch.
    logic signed [SAMPLE_BITS-1:0] held_samples [DEPTH];
    logic signed [SAMPLE_BITS-1:0] batch_lo = '0;
    logic signed [SAMPLE_BITS-1:0] batch_hi = '0;
    int unsigned                   held_count = 0;
    bit                            batch_overflow = 1'b0;

    norm_result_t pending_results [$];   // normalized values still owed by the block
    int           mismatch_cnt = 0;

    // Sender pacing: burst length left, and a switch for gap-free stretches.
    int burst_left = 0;
    bit tx_steady  = 1'b0;
    // Receiver pacing: when set, never stall.
    bit rx_steady  = 1'b0;

    min_max_normalize_batch uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Normalize one held sample against the batch range, truncated Q1.16.
    function automatic logic [SCALED_BITS-1:0] fraction_of(logic signed [SAMPLE_BITS-1:0] x);
        longint span;
        longint offset;
        span   = longint'(batch_hi) - longint'(batch_lo);
        offset = longint'(x) - longint'(batch_lo);
        if (span == 0)
            return '0;
        return SCALED_BITS'((offset <<< FRAC_BITS) / span);
    endfunction

    // Fold one accepted request into the predictor; on the last sample of a
    // batch, queue one expected result per held sample and close the batch.
    task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                 input logic is_last);
        norm_result_t r;
        bit           flat;
        if (held_count < DEPTH)
        begin
            if (held_count == 0)
            begin
                batch_lo = value;
                batch_hi = value;
            end
            else
            begin
                if (value < batch_lo)
                    batch_lo = value;
                if (value > batch_hi)
                    batch_hi = value;
            end
            held_samples[held_count] = value;
            held_count++;
        end
        else
        begin
            // buffer full: drop the sample, leave min and max alone
            batch_overflow = 1'b1;
        end

        if (is_last)
        begin
            flat = (batch_hi == batch_lo);
            for (int k = 0; k < held_count; k++)
            begin
                r.scaled       = flat ? '0 : fraction_of(held_samples[k]);
                r.final_result = (k + 1 == held_count);
                r.flat_range   = flat;
                r.dropped      = batch_overflow;
                pending_results.insert(pending_results.size(), r);
            end
            held_count     = 0;
            batch_overflow = 1'b0;
        end
    endtask

    // Offer one sample request and hold it until the block takes it. Between
    // bursts, unless tx_steady is set, drop valid for a random gap and scribble on the idle data lines.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                               input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            if (!tx_steady)
            begin
                gap = $urandom_range(1, 6);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    s_tdata  <= IN_DATA_BITS'($urandom);
                    s_tlast  <= 1'($urandom);
                end
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;

        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_BITS'(value);
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_sample(value, is_last);
    endtask

    // Park the sender until every owed result has come out.
    task automatic wait_for_results;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver backpressure: random runs of ready and stall, with long ready runs.
    initial
    begin
        int  run_len;
        logic level;
        run_len = 0;
        level   = 1'b1;
        forever
        begin
            @(negedge clk);
            if (run_len == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    level   = 1'b1;
                    run_len = 40;
                end
                else
                begin
                    level   = ($urandom_range(0, 9) < 7);
                    run_len = $urandom_range(1, 8);
                end
            end
            run_len--;
            m_tready <= rx_steady ? 1'b1 : level;
        end
    end

    // Check every result handshake against the oldest owed value.
    always @(posedge clk)
    begin
        norm_result_t             want;
        logic [OUT_DATA_BITS-1:0] want_data;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("%0t: unexpected result scaled=%0d last=%0b user=%b",
                             $realtime, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want      = pending_results.pop_front();
                want_data = OUT_DATA_BITS'(want.scaled);
                if (m_tdata !== want_data || m_tlast !== want.final_result
                    || m_tuser[FLAT_BIT] !== want.flat_range
                    || m_tuser[DROP_BIT] !== want.dropped)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                    begin
                        $write("%0t: mismatch exp scaled=%0d last=%0b flat=%0b drop=%0b",
                               $realtime, want_data, want.final_result, want.flat_range,
                               want.dropped);
                        $display(" | got scaled=%0d last=%0b flat=%0b drop=%0b",
                                 m_tdata, m_tlast, m_tuser[FLAT_BIT], m_tuser[DROP_BIT]);
                    end
                end
            end
        end
    end

    // A lone sample marked last: first-sample load plus a flat range.
    task automatic test_single_sample;
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    // Full-scale extremes in one batch, then an extremes-only batch.
    task automatic test_extremes;
        send_sample(16'sd0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    // Every sample equal: scaled forced to zero, flat flagged on each result.
    task automatic test_flat_batch;
        repeat (3)
            send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    // The new batch's first sample must replace the min/max left from before.
    task automatic test_batch_restart;
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd4, 1'b1);
        send_sample(16'sd200, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd300, 1'b1);
    endtask

    // Past DEPTH: extra samples lie outside the stored range and must not move
    // min or max; the dropped last sample still closes the batch.
    task automatic test_overflow;
        for (int i = 0; i < DEPTH; i++)
            send_sample(SAMPLE_BITS'($urandom_range(0, 200)) - 16'sd100, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    // Short random batches with varied value spreads and pacing.
    task automatic test_random_batches;
        int sent;
        int len;
        int kind;
        logic signed [SAMPLE_BITS-1:0] base;
        logic signed [SAMPLE_BITS-1:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len       = $urandom_range(1, 10);
            kind      = $urandom_range(0, 9);
            base      = SAMPLE_BITS'($urandom);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                if (kind < 5)
                    value = SAMPLE_BITS'($urandom);
                else if (kind < 8)
                    value = base + SAMPLE_BITS'($urandom_range(0, 15));  // tight cluster
                else if (kind == 8)
                    value = base;                                        // flat batch
                else
                    case ($urandom_range(0, 3))
                        0:       value = SAMPLE_MIN;
                        1:       value = SAMPLE_MAX;
                        2:       value = '0;
                        default: value = -16'sd1;
                    endcase
                send_sample(value, i == len - 1);
            end
            sent += len;
            if ($urandom_range(0, 7) == 0)
                wait_for_results;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_sample();
        test_extremes();
        wait_for_results();          // hold the sender until the block drains
        test_flat_batch();
        test_batch_restart();
        test_overflow();
        test_random_batches();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> min_max_normalize_batch.f
rtl/mmnb_pkg.sv
rtl/mmnb_ram.sv
rtl/mmnb_div.sv
rtl/min_max_normalize_batch.sv
tb/tb.sv
